### rtl/core/sdm_pkg.sv
// Shared widths, field offsets and the result record type for the duplicate marker.
`timescale 1ns / 1ps
package sdm_pkg;

  localparam int ID_BITS    = 48;
  localparam int NAME_BITS  = 32;
  localparam int CHROM_BITS = 16;
  localparam int POS_BITS   = 31;
  localparam int SRC_BITS   = 32;
  localparam int OUT_BITS   = 32;

  // input beat layout, lowest field first
  localparam int ID_LSB     = 0;
  localparam int NAME_LSB   = ID_LSB + ID_BITS;
  localparam int CHROM_LSB  = NAME_LSB + NAME_BITS;
  localparam int POS_LSB    = CHROM_LSB + CHROM_BITS;
  localparam int MCHROM_LSB = POS_LSB + POS_BITS;
  localparam int MPOS_LSB   = MCHROM_LSB + CHROM_BITS;
  localparam int SRC_LSB    = MPOS_LSB + POS_BITS;
  localparam int IN_USED    = SRC_LSB + SRC_BITS;
  localparam int IN_BITS    = ((IN_USED + 7) / 8) * 8;

  localparam int OUTD_BITS  = 2 * OUT_BITS;

  // result queue
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [OUT_BITS-1:0] name;
    logic [OUT_BITS-1:0] src;
    logic                primary;
    logic                fin;
  } res_t;

endpackage

### rtl/core/sorted_duplicate_marker_top.sv
// Top level of the sorted-stream duplicate marker.
//
//  channel | dir | payload                                      | handshake
//  in_     | in  | tdata: id, name, chrom, pos, mchrom, mpos, src | tvalid/tready
//  out_    | out | tdata: name, src; tuser: primary; tlast       | tvalid/tready
//
//  One beat is taken per cycle into the input register while it is not held;
//  its results are decided from that register and written to a four-entry result queue.
//  From input beat to first result beat, a record passes the input register and the queue.
//  The input register holds while the queue has fewer than two free slots.
//  A run's first duplicate yields two result beats, so the output side sets the
//  sustained rate to one result per cycle while out_tready is high.
//  Reset (rst_n low, synchronous) clears the run state and empties the queue.
`timescale 1ns / 1ps
module sorted_duplicate_marker_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // record_id, read_name, chrom, pos, mate_chrom, mate_pos, source, zero pad
  input  logic [sdm_pkg::IN_BITS-1:0] in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // read_name_out, source_out
  output logic [sdm_pkg::OUTD_BITS-1:0] out_tdata,
  // primary flag
  output logic                        out_tuser,
  output logic                        out_tlast
);
  import sdm_pkg::*;

  // input register
  logic                  in_vld_r;
  logic [ID_BITS-1:0]    id_r;
  logic [NAME_BITS-1:0]  name_r;
  logic [CHROM_BITS-1:0] chrom_r, mchrom_r;
  logic [POS_BITS-1:0]   pos_r, mpos_r;
  logic [SRC_BITS-1:0]   src_r;

  // run state
  logic                  have_prev_r, have_prev_nxt;
  logic                  run_dups_r, run_dups_nxt;
  logic [ID_BITS-1:0]    prev_id_r;
  logic [NAME_BITS-1:0]  prev_name_r, first_name_r, first_name_nxt;
  logic [CHROM_BITS-1:0] prev_chrom_r, prev_mchrom_r;
  logic [POS_BITS-1:0]   prev_pos_r, prev_mpos_r;
  logic [SRC_BITS-1:0]   prev_src_r;

  logic                  proceed, is_dup, same_name, keep;
  logic [1:0]            push_cnt;
  res_t                  push_a, push_b, head;
  logic [QCNT_BITS-1:0]  q_cnt;
  logic                  in_acc;

  assign proceed   = in_vld_r && (32'(q_cnt) <= QDEPTH - 2);
  assign in_tready = !in_vld_r || proceed;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      id_r     <= in_tdata[ID_LSB +: ID_BITS];
      name_r   <= in_tdata[NAME_LSB +: NAME_BITS];
      chrom_r  <= in_tdata[CHROM_LSB +: CHROM_BITS];
      pos_r    <= in_tdata[POS_LSB +: POS_BITS];
      mchrom_r <= in_tdata[MCHROM_LSB +: CHROM_BITS];
      mpos_r   <= in_tdata[MPOS_LSB +: POS_BITS];
      src_r    <= in_tdata[SRC_LSB +: SRC_BITS];
    end
  end

  assign is_dup = have_prev_r && (id_r != prev_id_r) &&
                  (chrom_r == prev_chrom_r) && (pos_r == prev_pos_r) &&
                  (mchrom_r == prev_mchrom_r) && (mpos_r == prev_mpos_r) &&
                  (src_r == prev_src_r);
  assign same_name = (name_r == prev_name_r);
  // a duplicate with the previous name is dropped and leaves the state alone
  assign keep = proceed && !(is_dup && same_name);

  always_comb begin
    have_prev_nxt  = have_prev_r;
    run_dups_nxt   = run_dups_r;
    first_name_nxt = first_name_r;
    push_cnt       = 2'd0;
    push_a.name    = OUT_BITS'(first_name_r);
    push_a.src     = OUT_BITS'(prev_src_r);
    push_a.primary = 1'b1;
    push_a.fin     = 1'b0;
    push_b.name    = OUT_BITS'(name_r);
    push_b.src     = OUT_BITS'(src_r);
    push_b.primary = 1'b0;
    push_b.fin     = 1'b1;
    if (keep) begin
      have_prev_nxt = 1'b1;
      if (!is_dup) begin
        first_name_nxt = name_r;
        run_dups_nxt   = 1'b0;
      end else begin
        run_dups_nxt = 1'b1;
        if (run_dups_r) begin
          push_cnt = 2'd1;
          push_a   = push_b;
        end else begin
          push_cnt = 2'd2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r  <= 1'b0;
      run_dups_r   <= 1'b0;
      first_name_r <= '0;
    end else begin
      have_prev_r  <= have_prev_nxt;
      run_dups_r   <= run_dups_nxt;
      first_name_r <= first_name_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_id_r     <= '0;
      prev_name_r   <= '0;
      prev_chrom_r  <= '0;
      prev_pos_r    <= '0;
      prev_mchrom_r <= '0;
      prev_mpos_r   <= '0;
      prev_src_r    <= '0;
    end else if (keep) begin
      prev_id_r     <= id_r;
      prev_name_r   <= name_r;
      prev_chrom_r  <= chrom_r;
      prev_pos_r    <= pos_r;
      prev_mchrom_r <= mchrom_r;
      prev_mpos_r   <= mpos_r;
      prev_src_r    <= src_r;
    end
  end

  sdm_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .push_a   (push_a),
    .push_b   (push_b),
    .pop      (out_tready),
    .head     (head),
    .count    (q_cnt)
  );

  assign out_tvalid = (q_cnt != '0);
  assign out_tdata  = {head.src, head.name};
  assign out_tuser  = head.primary;
  assign out_tlast  = head.fin;

  a_primary_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> !out_tlast)
    else $error("primary result marked last");

  a_dups_need_prev: assert property (@(posedge clk) disable iff (!rst_n)
    run_dups_r |-> have_prev_r)
    else $error("run marked emitted without a kept record");

  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) |-> (!have_prev_r && !run_dups_r && !in_vld_r))
    else $error("run state not cleared by reset");

  a_pair_on_new_run: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt == 2'd2) |-> (!run_dups_r && is_dup))
    else $error("primary pushed outside the first duplicate of a run");

endmodule

### rtl/core/sdm_outq.sv
// Small result queue: takes up to two results per cycle, delivers one while pop is high.
`timescale 1ns / 1ps
module sdm_outq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   push_cnt,
  input  sdm_pkg::res_t                push_a,
  input  sdm_pkg::res_t                push_b,
  input  logic                         pop,
  output sdm_pkg::res_t                head,
  output logic [sdm_pkg::QCNT_BITS-1:0] count
);
  import sdm_pkg::*;

  res_t                 mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_b;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 do_pop;

  assign do_pop = pop && (cnt_r != '0);
  assign wr_b   = wr_r + QPTR_BITS'(1);

  always_comb begin
    wr_nxt  = wr_r + QPTR_BITS'(push_cnt);
    rd_nxt  = do_pop ? rd_r + QPTR_BITS'(1) : rd_r;
    cnt_nxt = cnt_r + QCNT_BITS'(push_cnt) - QCNT_BITS'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_r] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_b] <= push_b;
    end
  end

  assign head  = mem_r[rd_r];
  assign count = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cnt_r) + 32'(push_cnt) - 32'(do_pop)) <= QDEPTH)
    else $error("result queue overflow");

  a_push_range: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd3)
    else $error("more than two results pushed in one cycle");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && cnt_r != '0 && push_cnt == 2'd0) |=> (cnt_r == $past(cnt_r) - QCNT_BITS'(1)))
    else $error("queue count did not drop on pop");

endmodule

### tb/sorted_duplicate_marker_check.sv
// Watches both channels of the duplicate marker, predicts each marked record and compares.
`timescale 1ns / 1ps
module sorted_duplicate_marker_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [sdm_pkg::IN_BITS-1:0]   in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [sdm_pkg::OUTD_BITS-1:0] out_tdata,
  input  logic                          out_tuser,
  input  logic                          out_tlast,
  output int                            mismatches,
  output int                            marks_waiting,
  output int                            marks_checked,
  output int                            dup_runs
);
  import sdm_pkg::*;

  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic [NAME_BITS-1:0]  name;
    logic [CHROM_BITS-1:0] chrom;
    logic [POS_BITS-1:0]   pos;
    logic [CHROM_BITS-1:0] mchrom;
    logic [POS_BITS-1:0]   mpos;
    logic [SRC_BITS-1:0]   src;
  } rec_t;

  logic                 have_kept;
  logic                 run_marked;
  rec_t                 kept;
  logic [NAME_BITS-1:0] run_first_name;
  res_t                 expected_marks[$];
  rec_t                 rec;
  res_t                 want;

  task automatic mark_record(input rec_t r);
    logic dup;
    res_t m;
    dup = have_kept && r.id != kept.id && r.chrom == kept.chrom && r.pos == kept.pos &&
          r.mchrom == kept.mchrom && r.mpos == kept.mpos && r.src == kept.src;
    if (!dup) begin
      run_first_name = r.name;
      run_marked = 1'b0;
    end else begin
      // same read name as the kept record: dropped, state untouched
      if (r.name == kept.name) return;
      if (!run_marked) begin
        m.name = OUT_BITS'(run_first_name);
        m.src = OUT_BITS'(kept.src);
        m.primary = 1'b1;
        m.fin = 1'b0;
        expected_marks.push_back(m);
        run_marked = 1'b1;
        dup_runs++;
      end
      m.name = OUT_BITS'(r.name);
      m.src = OUT_BITS'(r.src);
      m.primary = 1'b0;
      m.fin = 1'b1;
      expected_marks.push_back(m);
    end
    have_kept = 1'b1;
    kept = r;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      have_kept = 1'b0;
      run_marked = 1'b0;
      kept = '0;
      run_first_name = '0;
      expected_marks.delete();
      mismatches = 0;
      marks_checked = 0;
      dup_runs = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        rec.id = in_tdata[ID_LSB +: ID_BITS];
        rec.name = in_tdata[NAME_LSB +: NAME_BITS];
        rec.chrom = in_tdata[CHROM_LSB +: CHROM_BITS];
        rec.pos = in_tdata[POS_LSB +: POS_BITS];
        rec.mchrom = in_tdata[MCHROM_LSB +: CHROM_BITS];
        rec.mpos = in_tdata[MPOS_LSB +: POS_BITS];
        rec.src = in_tdata[SRC_LSB +: SRC_BITS];
        mark_record(rec);
      end
      if (out_tvalid && out_tready) begin
        if (expected_marks.size() == 0) begin
          $error("unexpected result beat: read_name_out %h source_out %h",
                 out_tdata[OUT_BITS-1:0], out_tdata[OUTD_BITS-1:OUT_BITS]);
          mismatches++;
        end else begin
          want = expected_marks.pop_front();
          marks_checked++;
          if (out_tdata[OUT_BITS-1:0] !== want.name) begin
            $error("read_name_out: expected %h, got %h", want.name, out_tdata[OUT_BITS-1:0]);
            mismatches++;
          end
          if (out_tdata[OUTD_BITS-1:OUT_BITS] !== want.src) begin
            $error("source_out: expected %h, got %h", want.src,
                   out_tdata[OUTD_BITS-1:OUT_BITS]);
            mismatches++;
          end
          if (out_tuser !== want.primary) begin
            $error("primary: expected %b, got %b", want.primary, out_tuser);
            mismatches++;
          end
          if (out_tlast !== want.fin) begin
            $error("last: expected %b, got %b", want.fin, out_tlast);
            mismatches++;
          end
        end
      end
    end
    marks_waiting <= expected_marks.size();
  end

endmodule

### tb/sorted_duplicate_marker_top_test.sv
// Testbench top for the duplicate marker: clock, reset, record stream, result sink and verdict.
`timescale 1ns / 1ps
module sorted_duplicate_marker_top_test;
  import sdm_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int HOLD_CYCLES  = 300;
  localparam int ITEM_TARGET  = 1550;
  localparam int DRAIN_CYCLES = 10;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_BITS-1:0]   in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUTD_BITS-1:0] out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;

  int mismatches;
  int marks_waiting;
  int marks_checked;
  int dup_runs;
  int records_sent;
  int records_counted;
  int cycles;
  bit hold_req;
  bit tx_burst;
  bit rx_burst;

  logic [ID_BITS-1:0]    kept_id;
  logic [NAME_BITS-1:0]  kept_name;
  logic [CHROM_BITS-1:0] k_chrom, k_mchrom;
  logic [POS_BITS-1:0]   k_pos, k_mpos;
  logic [SRC_BITS-1:0]   k_src;

  sorted_duplicate_marker_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  sorted_duplicate_marker_check marks_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .mismatches    (mismatches),
    .marks_waiting (marks_waiting),
    .marks_checked (marks_checked),
    .dup_runs      (dup_runs)
  );

  function automatic logic [IN_BITS-1:0] beat_of(
    input logic [ID_BITS-1:0]    id,
    input logic [NAME_BITS-1:0]  name,
    input logic [CHROM_BITS-1:0] chrom,
    input logic [POS_BITS-1:0]   pos,
    input logic [CHROM_BITS-1:0] mchrom,
    input logic [POS_BITS-1:0]   mpos,
    input logic [SRC_BITS-1:0]   src
  );
    logic [IN_BITS-1:0] b;
    b = '0;
    b[ID_LSB +: ID_BITS] = id;
    b[NAME_LSB +: NAME_BITS] = name;
    b[CHROM_LSB +: CHROM_BITS] = chrom;
    b[POS_LSB +: POS_BITS] = pos;
    b[MCHROM_LSB +: CHROM_BITS] = mchrom;
    b[MPOS_LSB +: POS_BITS] = mpos;
    b[SRC_LSB +: SRC_BITS] = src;
    return b;
  endfunction

  // mostly random, sometimes all zeros or all ones
  function automatic logic [31:0] key_value(input int bits);
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return 32'((64'd1 << bits) - 1);
    return $urandom;
  endfunction

  task automatic send_record(input logic [IN_BITS-1:0] b, input bit counted);
    int gap;
    gap = (hold_req || tx_burst) ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    records_sent++;
    if (counted) records_counted++;
    if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result sink
  initial begin
    int stall;
    out_tready <= 1'b0;
    wait (rst_n);
    forever begin
      stall = hold_req ? HOLD_CYCLES : (rx_burst ? 0 : $urandom_range(0, 16));
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        hold_req = 1'b0;
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
    end
  end

  initial begin
    logic [ID_BITS-1:0]    id;
    logic [NAME_BITS-1:0]  name;
    logic [CHROM_BITS-1:0] c, mc;
    logic [POS_BITS-1:0]   p, mp;
    logic [SRC_BITS-1:0]   s;
    int kind, len, field;
    bit skip;

    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    records_sent = 0;
    records_counted = 0;
    hold_req = 1'b0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    kept_id = '0;
    kept_name = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // first record with id zero, then a run that grows, a same-name repeat
    // and a same-id record that starts a new run
    send_record(beat_of('0, '0, '0, '0, '0, '0, '0), 1'b1);
    send_record(beat_of(ID_BITS'(1), 1, '0, '0, '0, '0, '0), 1'b1);
    send_record(beat_of(ID_BITS'(2), 1, '0, '0, '0, '0, '0), 1'b0);
    send_record(beat_of(ID_BITS'(2), 2, '0, '0, '0, '0, '0), 1'b1);
    send_record(beat_of(ID_BITS'(2), 3, '0, '0, '0, '0, '0), 1'b1);
    send_record(beat_of(ID_BITS'(3), 4, '0, '0, '0, '0, '0), 1'b1);
    // all-ones fields
    send_record(beat_of('1, '1, '1, '1, '1, '1, '1), 1'b1);
    send_record(beat_of('0, '0, '1, '1, '1, '1, '1), 1'b1);
    // one compared field off at a time breaks the run
    for (int k = 0; k < 5; k++) begin
      send_record(beat_of(ID_BITS'(100 + 2 * k), NAME_BITS'(100 + 2 * k),
                          {CHROM_BITS{k != 0}}, {POS_BITS{k != 1}}, {CHROM_BITS{k != 2}},
                          {POS_BITS{k != 3}}, {SRC_BITS{k != 4}}), 1'b1);
      send_record(beat_of(ID_BITS'(101 + 2 * k), NAME_BITS'(101 + 2 * k),
                          '1, '1, '1, '1, '1), 1'b1);
    end
    // a read name seen before is marked again
    send_record(beat_of(48'h5A5A, 1, '1, '1, '1, '1, '1), 1'b1);
    send_record(beat_of(48'h5A5B, 1, '1, '1, '1, '1, '1), 1'b0);

    hold_req = 1'b1;
    while (records_counted < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      k_chrom = CHROM_BITS'(key_value(CHROM_BITS));
      k_pos = POS_BITS'(key_value(POS_BITS));
      k_mchrom = CHROM_BITS'(key_value(CHROM_BITS));
      k_mpos = POS_BITS'(key_value(POS_BITS));
      k_src = SRC_BITS'(key_value(SRC_BITS));
      len = (kind == 0) ? 1 : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        id = ID_BITS'({$urandom, $urandom});
        name = ($urandom_range(0, 3) == 0) ? NAME_BITS'($urandom_range(0, 7)) : $urandom;
        c = k_chrom;
        p = k_pos;
        mc = k_mchrom;
        mp = k_mpos;
        s = k_src;
        skip = 1'b0;
        if (i > 0 && $urandom_range(0, 9) == 0) begin
          id = kept_id;
        end else if (i > 0 && $urandom_range(0, 5) == 0) begin
          name = kept_name;
          skip = 1'b1;
        end
        // broken run: last member has one key bit flipped
        if (kind == 1 && i > 0 && i == len - 1) begin
          field = $urandom_range(0, 4);
          case (field)
            0: c[$urandom_range(0, CHROM_BITS - 1)] ^= 1'b1;
            1: p[$urandom_range(0, POS_BITS - 1)] ^= 1'b1;
            2: mc[$urandom_range(0, CHROM_BITS - 1)] ^= 1'b1;
            3: mp[$urandom_range(0, POS_BITS - 1)] ^= 1'b1;
            default: s[$urandom_range(0, SRC_BITS - 1)] ^= 1'b1;
          endcase
          skip = 1'b0;
        end
        send_record(beat_of(id, name, c, p, mc, mp, s), !skip);
        if (!skip) begin
          kept_id = id;
          kept_name = name;
        end
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (marks_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d records (%0d not dropped as same-name repeats), checked %0d marks",
             records_sent, records_counted, marks_checked);
    $display("from %0d duplicate runs, with random gaps and a %0d-cycle output stall",
             dup_runs, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sorted_duplicate_marker_top.f
rtl/core/sdm_pkg.sv
rtl/core/sdm_outq.sv
rtl/core/sorted_duplicate_marker_top.sv
tb/sorted_duplicate_marker_check.sv
tb/sorted_duplicate_marker_top_test.sv
